// ===== design/tlsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsd_pkg: shared types and constants for the tail lamp signal decoder
// Word layouts of both channels, effect codes, register indexes and the
// flag group passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package tlsd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NOW_W      = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_SETTLE  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] BLINK_TIMEOUT_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] BRAKE_SETTLE_RST  = 16'd75;

  // effect codes
  localparam logic [2:0] FX_OFF       = 3'd0;
  localparam logic [2:0] FX_LEFT_OFF  = 3'd1;
  localparam logic [2:0] FX_RIGHT_OFF = 3'd2;
  localparam logic [2:0] FX_BLINK     = 3'd3;
  localparam logic [2:0] FX_BRAKE     = 3'd4;
  localparam logic [2:0] FX_BACKUP    = 3'd5;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic             brake_line;
    logic             left_line;
    logic             right_line;
    logic             reverse_line;
  } in_t;

  typedef struct packed {
    logic [2:0] effect;
    logic       blink_side;
    logic       restart;
    logic       brake_level;
  } out_t;

  typedef struct packed {
    logic       brake_latched;
    logic       settling;
    logic       left_active;
    logic       right_active;
    logic       off_phase;
    logic       side_reg;
    logic [2:0] current_effect;
  } flags_t;

endpackage

// ===== design/tail_lamp_signal_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tail_lamp_signal_decoder_top: tail lamp line decoder
// Turns timestamped samples of the brake, turn and reverse lines into the
// lighting effect, blink side, restart flag and latched brake level.
// ----------------------------------------------------------------------------
//   channel   signals                        word
//   in        in_valid / in_ready / in_data  tlsd_pkg::in_t, one lamp sample
//   out       out_valid / out_ready / out_data  tlsd_pkg::out_t, one decision
//   cfg       cfg_valid / cfg_ready, cfg_index / cfg_data  16-bit register write
//
// one sample per cycle sustained while the output is not stalled; a sample passes
// through the input register, then decision logic into the result register.
// the decision state lives in flip-flops updated in the same cycle the result
// register loads, so back-to-back samples see the previous sample's state.
// a stalled output holds the result; the input register still takes one more
// word, after which in_ready drops. rst is synchronous and clears all state but the data words.
// ----------------------------------------------------------------------------
module tail_lamp_signal_decoder_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tlsd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tlsd_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [tlsd_pkg::CFG_DATA_W-1:0] blink_timeout_ms;
  logic [tlsd_pkg::CFG_DATA_W-1:0] brake_settle_ms;

  logic                 s1_valid;
  tlsd_pkg::in_t        s1_data;
  logic                 advance;

  tlsd_pkg::flags_t     flags;
  tlsd_pkg::flags_t     flags_next;
  logic [TIME_BITS-1:0] settle_start;
  logic [TIME_BITS-1:0] settle_start_next;
  logic [TIME_BITS-1:0] left_seen;
  logic [TIME_BITS-1:0] left_seen_next;
  logic [TIME_BITS-1:0] right_seen;
  logic [TIME_BITS-1:0] right_seen_next;
  tlsd_pkg::out_t       result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_timeout_ms <= tlsd_pkg::BLINK_TIMEOUT_RST;
      brake_settle_ms  <= tlsd_pkg::BRAKE_SETTLE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlsd_pkg::CFG_BLINK_TIMEOUT: blink_timeout_ms <= cfg_data;
        tlsd_pkg::CFG_BRAKE_SETTLE:  brake_settle_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // decide when a sample is held and the result slot is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  tlsd_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item              (s1_data),
    .blink_timeout_ms  (blink_timeout_ms),
    .brake_settle_ms   (brake_settle_ms),
    .flags             (flags),
    .settle_start      (settle_start),
    .left_seen         (left_seen),
    .right_seen        (right_seen),
    .flags_next        (flags_next),
    .settle_start_next (settle_start_next),
    .left_seen_next    (left_seen_next),
    .right_seen_next   (right_seen_next),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      settle_start <= '0;
      left_seen    <= '0;
      right_seen   <= '0;
    end else if (advance) begin
      flags        <= flags_next;
      settle_start <= settle_start_next;
      left_seen    <= left_seen_next;
      right_seen   <= right_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // the word just loaded reports the state it left behind
  a_effect_tracks_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_data.effect == flags.current_effect &&
                out_data.brake_level == flags.brake_latched)
    else $error("result word disagrees with held state");

  a_effect_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.effect <= tlsd_pkg::FX_BACKUP)
    else $error("effect code out of range");

  // input only stalls when a sample waits behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_state_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(flags) && $stable(left_seen) && $stable(right_seen))
    else $error("decision state moved without a sample");
`endif

endmodule

// ===== design/tlsd_step.sv =====
// ----------------------------------------------------------------------------
// tlsd_step: one-sample decision logic
// Brake lockout, per-side turn tracking and effect selection for one word,
// purely combinational between the input stage and the result register.
// ----------------------------------------------------------------------------
module tlsd_step #(
  parameter int TIME_BITS = 32
) (
  input  tlsd_pkg::in_t                    item,
  input  logic [tlsd_pkg::CFG_DATA_W-1:0]  blink_timeout_ms,
  input  logic [tlsd_pkg::CFG_DATA_W-1:0]  brake_settle_ms,
  input  tlsd_pkg::flags_t                 flags,
  input  logic [TIME_BITS-1:0]             settle_start,
  input  logic [TIME_BITS-1:0]             left_seen,
  input  logic [TIME_BITS-1:0]             right_seen,
  output tlsd_pkg::flags_t                 flags_next,
  output logic [TIME_BITS-1:0]             settle_start_next,
  output logic [TIME_BITS-1:0]             left_seen_next,
  output logic [TIME_BITS-1:0]             right_seen_next,
  output tlsd_pkg::out_t                   result
);

  logic [63:0]          now_ext;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] settle_el;
  logic [TIME_BITS-1:0] seen_el [2];
  logic                 timed_out [2];
  logic                 act [2];
  logic                 line [2];
  logic                 seen_set [2];
  logic                 activity;
  logic                 other;
  logic                 sb;
  logic [2:0]           side_off;
  logic                 chg;
  tlsd_pkg::flags_t     f;

  assign now_ext = {32'd0, item.now_ms};
  assign now     = now_ext[TIME_BITS-1:0];

  assign settle_el    = now - settle_start;
  assign seen_el[0]   = now - left_seen;
  assign seen_el[1]   = now - right_seen;
  assign timed_out[0] = seen_el[0] >= TIME_BITS'(blink_timeout_ms);
  assign timed_out[1] = seen_el[1] >= TIME_BITS'(blink_timeout_ms);

  always_comb begin
    f                 = flags;
    chg               = 1'b0;
    settle_start_next = settle_start;
    act[0]            = flags.left_active;
    act[1]            = flags.right_active;
    line[0]           = item.left_line;
    line[1]           = item.right_line;
    seen_set[0]       = 1'b0;
    seen_set[1]       = 1'b0;
    activity          = 1'b0;
    other             = 1'b0;
    sb                = 1'b0;
    side_off          = tlsd_pkg::FX_LEFT_OFF;

    if (f.settling && settle_el >= TIME_BITS'(brake_settle_ms)) begin
      f.settling = 1'b0;
    end

    if (!f.settling) begin
      if (f.brake_latched != item.brake_line) begin
        f.brake_latched   = item.brake_line;
        f.settling        = 1'b1;
        settle_start_next = now;
      end else if (item.reverse_line) begin
        if (f.current_effect != tlsd_pkg::FX_BACKUP) chg = 1'b1;
        f.current_effect = tlsd_pkg::FX_BACKUP;
      end else begin
        // left first, then right; right sees the updated left activity
        for (int s = 0; s < 2; s++) begin
          sb       = 1'(s);
          other    = sb ? act[0] : act[1];
          activity = f.brake_latched ? !line[sb] : line[sb];
          side_off = sb ? tlsd_pkg::FX_RIGHT_OFF : tlsd_pkg::FX_LEFT_OFF;
          if (act[sb]) begin
            if (f.brake_latched == activity) begin
              // turn lamp dark: off phase (brake on drop, or no rise)
              if (f.brake_latched || !timed_out[sb]) begin
                f.off_phase = 1'b1;
                if (f.current_effect != side_off) chg = 1'b1;
                f.current_effect = side_off;
                seen_set[sb]     = f.brake_latched;
              end else begin
                act[sb] = 1'b0;
                if (f.current_effect != tlsd_pkg::FX_OFF) chg = 1'b1;
                f.current_effect = tlsd_pkg::FX_OFF;
              end
            end else begin
              // turn lamp lit, or idle under brake
              if (!f.brake_latched || !timed_out[sb]) begin
                if (f.off_phase) begin
                  if (f.current_effect != tlsd_pkg::FX_BLINK) chg = 1'b1;
                  f.current_effect = tlsd_pkg::FX_BLINK;
                  f.side_reg       = sb;
                end
                f.off_phase  = 1'b0;
                seen_set[sb] = !f.brake_latched;
              end else begin
                act[sb] = 1'b0;
                if (f.current_effect != tlsd_pkg::FX_OFF) chg = 1'b1;
                f.current_effect = tlsd_pkg::FX_OFF;
              end
            end
          end else if (activity && !other) begin
            act[sb]      = 1'b1;
            seen_set[sb] = 1'b1;
            if (f.current_effect != tlsd_pkg::FX_BLINK) chg = 1'b1;
            f.current_effect = tlsd_pkg::FX_BLINK;
            f.side_reg       = sb;
          end
        end
        if (!act[0] && !act[1]) begin
          if (f.brake_latched) begin
            if (f.current_effect != tlsd_pkg::FX_BRAKE) chg = 1'b1;
            f.current_effect = tlsd_pkg::FX_BRAKE;
          end else begin
            if (f.current_effect != tlsd_pkg::FX_OFF) chg = 1'b1;
            f.current_effect = tlsd_pkg::FX_OFF;
          end
        end
      end
    end

    f.left_active  = act[0];
    f.right_active = act[1];
  end

  assign flags_next         = f;
  assign left_seen_next     = seen_set[0] ? now : left_seen;
  assign right_seen_next    = seen_set[1] ? now : right_seen;
  assign result.effect      = f.current_effect;
  assign result.blink_side  = f.side_reg;
  assign result.restart     = chg;
  assign result.brake_level = f.brake_latched;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tail lamp signal decoder
// Lamp samples are queued by a stimulus process and fed to the block by a
// driver with random gaps. The driver predicts every accepted sample's
// decision, and a monitor with random back-pressure compares each result
// word against the oldest prediction. Register settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 100;
  localparam int PHASE_SAMPLES  = 250;

  // indexes past the two real registers, writes there must be ignored
  localparam logic [tlsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tlsd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  tlsd_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  tlsd_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tlsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tlsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tail_lamp_signal_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // decision state mirrored from the block
  logic [15:0] timeout_ms = tlsd_pkg::BLINK_TIMEOUT_RST;
  logic [15:0] settle_ms  = tlsd_pkg::BRAKE_SETTLE_RST;
  logic        brake_on   = 1'b0;
  logic        lockout    = 1'b0;
  logic [31:0] lockout_t0 = '0;
  logic        left_on    = 1'b0;
  logic        right_on   = 1'b0;
  logic [31:0] left_t     = '0;
  logic [31:0] right_t    = '0;
  logic        off_ph     = 1'b0;
  logic        side_q     = 1'b0;
  logic [2:0]  fx_q       = tlsd_pkg::FX_OFF;
  logic        fx_changed = 1'b0;

  tlsd_pkg::in_t  lamp_samples[$];
  tlsd_pkg::out_t pending_decisions[$];
  tlsd_pkg::out_t want_word;

  logic        in_taken   = 1'b0;
  int          tx_wait    = 0;
  int          rx_wait    = 0;
  int          hold_cnt   = 0;
  logic        hold_req   = 1'b0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int          err_count  = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms   = '0;

  function automatic void set_fx(logic [2:0] fx);
    if (fx_q != fx) begin
      fx_q = fx;
      fx_changed = 1'b1;
    end
  endfunction

  function automatic void resume_blink(logic side);
    logic was;
    was = off_ph;
    off_ph = 1'b0;
    if (was) begin
      set_fx(tlsd_pkg::FX_BLINK);
      side_q = side;
    end
  endfunction

  // side 0 left, 1 right
  function automatic void track_turn(logic side, logic line, logic [31:0] now);
    logic        act;
    logic        other;
    logic        activity;
    logic        expired;
    logic [31:0] seen;
    logic [2:0]  dark_fx;
    act      = side ? right_on : left_on;
    other    = side ? left_on : right_on;
    seen     = side ? right_t : left_t;
    dark_fx  = side ? tlsd_pkg::FX_RIGHT_OFF : tlsd_pkg::FX_LEFT_OFF;
    // with the brake lit a turn shows as the line dropping
    activity = brake_on ? !line : line;
    expired  = (now - seen) >= {16'd0, timeout_ms};
    if (act) begin
      if (brake_on) begin
        if (activity) begin
          off_ph = 1'b1;
          set_fx(dark_fx);
          seen = now;
        end else if (expired) begin
          act = 1'b0;
          set_fx(tlsd_pkg::FX_OFF);
        end else begin
          resume_blink(side);
        end
      end else begin
        if (activity) begin
          resume_blink(side);
          seen = now;
        end else if (expired) begin
          act = 1'b0;
          set_fx(tlsd_pkg::FX_OFF);
        end else begin
          off_ph = 1'b1;
          set_fx(dark_fx);
        end
      end
    end else if (activity && !other) begin
      act  = 1'b1;
      seen = now;
      set_fx(tlsd_pkg::FX_BLINK);
      side_q = side;
    end
    if (side) begin
      right_on = act;
      right_t  = seen;
    end else begin
      left_on = act;
      left_t  = seen;
    end
  endfunction

  function automatic tlsd_pkg::out_t decide_lamps(tlsd_pkg::in_t s);
    tlsd_pkg::out_t r;
    fx_changed = 1'b0;
    if (lockout && (s.now_ms - lockout_t0) >= {16'd0, settle_ms}) lockout = 1'b0;
    if (!lockout) begin
      if (s.brake_line != brake_on) begin
        brake_on   = s.brake_line;
        lockout    = 1'b1;
        lockout_t0 = s.now_ms;
      end else if (s.reverse_line) begin
        set_fx(tlsd_pkg::FX_BACKUP);
      end else begin
        track_turn(1'b0, s.left_line, s.now_ms);
        track_turn(1'b1, s.right_line, s.now_ms);
        if (!left_on && !right_on) set_fx(brake_on ? tlsd_pkg::FX_BRAKE : tlsd_pkg::FX_OFF);
      end
    end
    r.effect      = fx_q;
    r.blink_side  = side_q;
    r.restart     = fx_changed;
    r.brake_level = brake_on;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic void add_sample(logic [31:0] t, logic b, logic l, logic r, logic v);
    tlsd_pkg::in_t s;
    s.now_ms       = t;
    s.brake_line   = b;
    s.left_line    = l;
    s.right_line   = r;
    s.reverse_line = v;
    lamp_samples.push_back(s);
  endfunction

  // driver: handshake seen at the rising edge, next word presented at the falling edge
  always @(posedge clk) in_taken = !rst && in_valid && in_ready;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_taken) pending_decisions.push_back(decide_lamps(in_data));
      if (in_valid && !in_taken) begin
        // word still waiting, hold it
      end else if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (lamp_samples.size() != 0) begin
        in_data  <= lamp_samples.pop_front();
        in_valid <= 1'b1;
        tx_wait = tx_idle_on ? int'($urandom_range(0, 13)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected word effect %0d side %0d restart %0d brake %0d",
                        out_data.effect, out_data.blink_side, out_data.restart,
                        out_data.brake_level));
      end else begin
        want_word = pending_decisions.pop_front();
        if (out_data !== want_word)
          report_mismatch($sformatf(
            "effect %0d/%0d side %0d/%0d restart %0d/%0d brake %0d/%0d (got/want)",
            out_data.effect, want_word.effect, out_data.blink_side, want_word.blink_side,
            out_data.restart, want_word.restart, out_data.brake_level,
            want_word.brake_level));
      end
      rx_wait = rx_idle_on ? int'($urandom_range(0, 13)) : 0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [tlsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlsd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tlsd_pkg::CFG_BLINK_TIMEOUT: timeout_ms = val;
      tlsd_pkg::CFG_BRAKE_SETTLE:  settle_ms  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (lamp_samples.size() != 0 || in_valid || pending_decisions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed blink runs, some brake flicker and some pure noise
  task automatic queue_random(int n);
    int unsigned tmo;
    int unsigned half;
    int unsigned len;
    int unsigned kind;
    logic        brk;
    logic        sel;
    logic        hazard;
    logic        turn;
    logic [31:0] t0;
    tmo = 32'(timeout_ms);
    while (n > 0) begin
      kind   = $urandom_range(0, 9);
      len    = $urandom_range(8, 40);
      brk    = 1'($urandom_range(0, 1));
      sel    = 1'($urandom_range(0, 1));
      hazard = ($urandom_range(0, 7) == 0);
      half   = $urandom_range(1, tmo + tmo / 4 + 1);
      t0     = clock_ms;
      for (int i = 0; i < len && n > 0; i++) begin
        if (kind <= 6) begin
          clock_ms += $urandom_range(0, half / 2 + 1);
          turn = ((((clock_ms - t0) / half) % 2) == 0) ? !brk : brk;
          add_sample(clock_ms, brk, sel && !hazard ? brk : turn,
                     !sel && !hazard ? brk : turn, $urandom_range(0, 31) == 0);
        end else if (kind <= 8) begin
          // brake line chattering around the lockout time
          clock_ms += $urandom_range(0, int'(settle_ms) / 2 + 2);
          if ($urandom_range(0, 3) == 0) brk = !brk;
          add_sample(clock_ms, brk, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
        end else begin
          if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
          else clock_ms += $urandom_range(0, 2 * tmo + 2);
          add_sample(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        n--;
      end
    end
  endtask

  initial begin
    int unsigned tmo;
    int unsigned stl;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: blink, both sides, timeout, brake lockout, wrap
    add_sample(32'd0,    1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'd5,    1'b0, 1'b0, 1'b0, 1'b1);
    add_sample(32'd10,   1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'd20,   1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'd30,   1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'd40,   1'b0, 1'b1, 1'b1, 1'b0);
    add_sample(32'd2000, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'd2010, 1'b0, 1'b0, 1'b1, 1'b0);
    add_sample(32'd2020, 1'b1, 1'b1, 1'b1, 1'b0);
    add_sample(32'd2050, 1'b1, 1'b1, 1'b0, 1'b1);
    add_sample(32'd2095, 1'b1, 1'b1, 1'b0, 1'b0);
    add_sample(32'd2100, 1'b1, 1'b1, 1'b1, 1'b0);
    add_sample(32'd4000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_sample(32'd4010, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'h0000_0004, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'h0000_0010, 1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'h0000_0020, 1'b0, 1'b1, 1'b1, 1'b1);
    add_sample(32'h0000_1000, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(32'h0000_1100, 1'b1, 1'b1, 1'b1, 1'b0);
    add_sample(32'h0000_1110, 1'b1, 1'b0, 1'b1, 1'b0);
    drain();

    // shortest timeout, no lockout, spare indexes written
    write_reg(tlsd_pkg::CFG_BLINK_TIMEOUT, 16'd1);
    write_reg(tlsd_pkg::CFG_BRAKE_SETTLE, 16'd0);
    write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
    add_sample(32'd100, 1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'd101, 1'b0, 1'b1, 1'b0, 1'b0);
    add_sample(32'd101, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'd102, 1'b0, 1'b0, 1'b0, 1'b0);
    add_sample(32'd103, 1'b1, 1'b0, 1'b0, 1'b0);
    add_sample(32'd103, 1'b1, 1'b0, 1'b0, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          tmo = 32'(tlsd_pkg::BLINK_TIMEOUT_RST);
          stl = 32'(tlsd_pkg::BRAKE_SETTLE_RST);
        end
        1: begin
          tmo = 65535;
          stl = 65535;
        end
        2: begin
          tmo = 1;
          stl = 0;
        end
        3: begin
          tmo = 300;
          stl = 50;
        end
        4: begin
          tmo = $urandom_range(1, 2000);
          stl = $urandom_range(0, 300);
        end
        default: begin
          tmo = $urandom_range(1, 65535);
          stl = $urandom_range(0, 65535);
        end
      endcase
      write_reg(tlsd_pkg::CFG_BLINK_TIMEOUT, 16'(tmo));
      write_reg(tlsd_pkg::CFG_BRAKE_SETTLE, 16'(stl));
      tx_idle_on = (ph != 1 && ph != 3);
      rx_idle_on = (ph != 1);
      if (ph == 5) clock_ms = 32'hFFFF_0000;
      queue_random(PHASE_SAMPLES);
      // long receiver stall while the sender keeps pushing
      if (ph == 3) hold_req = 1'b1;
      drain();
    end

    if (pending_decisions.size() != 0) report_mismatch("results missing at end of run");
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
